// ===== sv/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser, the result register and the top level; no dependencies.
package wsd_pkg;

  // Parse phases, one-hot coded.
  typedef enum logic [4:0] {
    PH_HDR1   = 5'b00001,
    PH_HDR2   = 5'b00010,
    PH_EXTLEN = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  // Short-length codes that announce an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Byte counts of the extended length fields and of the masking key.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result beat.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic       frame_fin;
    logic [3:0] frame_opcode;
    logic       end_of_frame;
  } result_t;

endpackage

// ===== sv/wsd_parser.sv =====
// Header parser, length and key collection, and payload unmasking.
// Depends on wsd_pkg for the phase type, length codes and result type.
module wsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  input  logic               buffer_start,
  output logic               res_load,
  output wsd_pkg::result_t   res
);

  wsd_pkg::phase_t phase, phase_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        mask_present, mask_present_next;
  logic [3:0]  field_bytes_left, field_bytes_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [31:0] key_word, key_word_next;
  logic [1:0]  key_index, key_index_next;

  wsd_pkg::phase_t eff_phase;
  logic [6:0]  len7;
  logic [63:0] len_shifted;
  logic [3:0]  count_dec;
  logic [7:0]  key_byte;

  // A forced start overrides whatever frame is in progress.
  assign eff_phase   = buffer_start ? wsd_pkg::PH_HDR1 : phase;
  assign len7        = rx_byte[6:0];
  assign len_shifted = {payload_left[55:0], rx_byte};
  assign count_dec   = field_bytes_left - 4'd1;

  // Key byte for the current payload position; the first key byte is the top byte.
  always_comb begin
    case (key_index)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
  end

  // Next-state and result logic for one byte.
  always_comb begin
    phase_next            = eff_phase;
    fin_flag_next         = fin_flag;
    opcode_reg_next       = opcode_reg;
    mask_present_next     = mask_present;
    field_bytes_left_next = field_bytes_left;
    payload_left_next     = payload_left;
    key_word_next         = key_word;
    key_index_next        = key_index;
    res_load              = 1'b0;
    res.payload_byte      = 8'd0;
    res.has_data          = 1'b0;
    res.frame_fin         = fin_flag;
    res.frame_opcode      = opcode_reg;
    res.end_of_frame      = 1'b1;

    unique case (eff_phase)
      wsd_pkg::PH_HDR1: begin
        fin_flag_next         = rx_byte[7];
        opcode_reg_next       = rx_byte[3:0];
        mask_present_next     = 1'b0;
        field_bytes_left_next = 4'd0;
        payload_left_next     = 64'd0;
        key_word_next         = 32'd0;
        key_index_next        = 2'd0;
        phase_next            = wsd_pkg::PH_HDR2;
      end
      wsd_pkg::PH_HDR2: begin
        mask_present_next = rx_byte[7];
        if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
          payload_left_next     = 64'd0;
          field_bytes_left_next = (len7 == wsd_pkg::LEN_EXT16) ?
                                  wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
          phase_next            = wsd_pkg::PH_EXTLEN;
        end else begin
          payload_left_next = {57'd0, len7};
          if (rx_byte[7]) begin
            field_bytes_left_next = wsd_pkg::KEY_BYTES;
            phase_next            = wsd_pkg::PH_KEY;
          end else if (len7 == 7'd0) begin
            phase_next = wsd_pkg::PH_HDR1;
            res_load   = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        payload_left_next     = len_shifted;
        field_bytes_left_next = count_dec;
        if (count_dec == 4'd0) begin
          if (mask_present) begin
            field_bytes_left_next = wsd_pkg::KEY_BYTES;
            phase_next            = wsd_pkg::PH_KEY;
          end else if (len_shifted == 64'd0) begin
            phase_next = wsd_pkg::PH_HDR1;
            res_load   = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_word_next         = {key_word[23:0], rx_byte};
        field_bytes_left_next = count_dec;
        if (count_dec == 4'd0) begin
          if (payload_left == 64'd0) begin
            phase_next = wsd_pkg::PH_HDR1;
            res_load   = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        res_load          = 1'b1;
        res.has_data      = 1'b1;
        res.payload_byte  = mask_present ? (rx_byte ^ key_byte) : rx_byte;
        res.end_of_frame  = (payload_left == 64'd1);
        key_index_next    = key_index + 2'd1;
        payload_left_next = payload_left - 64'd1;
        if (payload_left == 64'd1) begin
          phase_next = wsd_pkg::PH_HDR1;
        end
      end
      default: begin
        phase_next = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  // Parser state advances only when a byte is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wsd_pkg::PH_HDR1;
      fin_flag         <= 1'b0;
      opcode_reg       <= 4'd0;
      mask_present     <= 1'b0;
      field_bytes_left <= 4'd0;
      payload_left     <= 64'd0;
      key_word         <= 32'd0;
      key_index        <= 2'd0;
    end else if (fire) begin
      phase            <= phase_next;
      fin_flag         <= fin_flag_next;
      opcode_reg       <= opcode_reg_next;
      mask_present     <= mask_present_next;
      field_bytes_left <= field_bytes_left_next;
      payload_left     <= payload_left_next;
      key_word         <= key_word_next;
      key_index        <= key_index_next;
    end
  end

endmodule

// ===== sv/wsd_out_reg.sv =====
// Result register holding one beat for the downstream channel.
// Depends on wsd_pkg for the result type.
module wsd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  wsd_pkg::result_t   din,
  output logic               free,
  input  logic               res_ready,
  output logic               res_valid,
  output wsd_pkg::result_t   dout
);

  // The register can take a new beat when empty or when its beat leaves now.
  assign free = !res_valid || res_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (free && load) begin
      dout <= din;
    end
  end

endmodule

// ===== sv/websocket_frame_deframer_core.sv =====
// WebSocket receive-side frame deframer: input register, parser and result register.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
// Usage:
//   Received bytes enter on the rx channel (rx_valid/rx_ready) with rx_byte and
//   buffer_start; buffer_start forces the byte to be taken as a first header byte.
//   Each beat gives zero or one result beat on the res channel (res_valid/res_ready):
//   an unmasked payload byte, or an empty-frame marker with has_data low.
//   Header, extended length and masking key bytes give no result, except the byte
//   that completes the header of an empty frame.
//   A result passes from the input register through the parser logic into the
//   result register, from which it leaves on the res channel.
//   Throughput: one byte per cycle while rx_ready is high, limited by the single
//   parser pass per cycle. When the receiver stalls, the result register holds its
//   beat; one more byte waits in the input register, and rx_ready drops only if
//   that byte would produce a result while the result register is still occupied.
//   Synchronous reset clears both registers and returns the parser to expect a
//   first header byte.
module websocket_frame_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       buffer_start,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] payload_byte,
  output logic       has_data,
  output logic       frame_fin,
  output logic [3:0] frame_opcode,
  output logic       end_of_frame
);

  logic             stg_valid;
  logic [7:0]       stg_byte;
  logic             stg_start;
  logic             stg_fire;
  logic             res_load;
  logic             out_free;
  wsd_pkg::result_t res_next;
  wsd_pkg::result_t res_q;

  // The staged byte is processed unless its result would find the register full.
  assign stg_fire = stg_valid && (!res_load || out_free);
  assign rx_ready = !stg_valid || stg_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (rx_ready) begin
      stg_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      stg_byte  <= rx_byte;
      stg_start <= buffer_start;
    end
  end

  wsd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (stg_fire),
    .rx_byte      (stg_byte),
    .buffer_start (stg_start),
    .res_load     (res_load),
    .res          (res_next)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (stg_fire && res_load),
    .din       (res_next),
    .free      (out_free),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .dout      (res_q)
  );

  // Result fields.
  assign payload_byte = res_q.payload_byte;
  assign has_data     = res_q.has_data;
  assign frame_fin    = res_q.frame_fin;
  assign frame_opcode = res_q.frame_opcode;
  assign end_of_frame = res_q.end_of_frame;

endmodule
